// ===== src/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg
// shared constants and types for the saturating lowpass fir filter
// ----------------------------------------------------------------------------
package fls_pkg;

  localparam int COEF_BITS  = 18;
  localparam int FRAC_SHIFT = 16;
  localparam int TAPS_BITS  = 6;
  localparam int IDX_BITS   = 5;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic REG_TAPS_IN_USE = 1'b0;

  localparam logic [TAPS_BITS-1:0] TAPS_RESET = 6'd32;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage

// ===== src/fls_if.sv =====
// ----------------------------------------------------------------------------
// fls_in_if / fls_out_if
// valid/ready channels carrying request beats and filtered result beats
// ----------------------------------------------------------------------------
interface fls_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic [fls_pkg::IDX_BITS-1:0]           coef_index;
  logic signed [fls_pkg::COEF_BITS-1:0]   coef_value;
  logic signed [SAMPLE_BITS-1:0]          sample_in;

  modport source (output valid, req_type, coef_index, coef_value, sample_in, input ready);
  modport sink   (input valid, req_type, coef_index, coef_value, sample_in, output ready);
endinterface

interface fls_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

// ===== src/fls_mac.sv =====
// ----------------------------------------------------------------------------
// fls_mac
// shared multiply-accumulate with rounding to the sample format and clamping
// ----------------------------------------------------------------------------
module fls_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fls_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [SAMPLE_BITS-1:0]        smp,
  input  logic signed [fls_pkg::COEF_BITS-1:0] coef,
  output logic                                 busy,
  output logic signed [SAMPLE_BITS-1:0]        res_filt,
  output logic                                 res_sat
);
  import fls_pkg::*;

  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;
  localparam int RW    = ACC_W - FRAC_SHIFT;

  logic signed [PW-1:0]    prod_r;
  logic                    p_vld_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] rsum;
  logic signed [RW-1:0]    rnd;
  logic                    over;
  logic                    under;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.vld) prod_r <= smp * coef;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (p_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then floor shift
  assign rsum  = acc_r + ACC_W'(signed'({1'b0, 1'b1, {(FRAC_SHIFT-1){1'b0}}}));
  assign rnd   = RW'(rsum >>> FRAC_SHIFT);
  assign over  = !rnd[RW-1] && (rnd[RW-2:SAMPLE_BITS-1] != '0);
  assign under = rnd[RW-1] && (rnd[RW-2:SAMPLE_BITS-1] != '1);

  always_comb begin
    res_sat = over || under;
    priority if (over) begin
      res_filt = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (under) begin
      res_filt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_filt = rnd[SAMPLE_BITS-1:0];
    end
  end

  assign busy = p_vld_r;

endmodule

// ===== src/fir_lowpass_saturating.sv =====
// ----------------------------------------------------------------------------
// fir_lowpass_saturating
// direct-form fir filter, one shared multiply-accumulate, saturated output
// ----------------------------------------------------------------------------
// A coefficient beat, or a sample beat that arrives before the window holds
// taps_in_use samples, yields no result and leaves the input ready. A sample
// beat on a full window yields one result and keeps the input stalled until
// that result is registered, which is held off while the previous result beat
// still waits at the output: the single multiplier takes one tap per cycle
// from the one read port of each store, then a read register, a product
// register and the accumulate stage drain. taps_in_use is 0 -> 1 tap, above
// MAX_TAPS -> MAX_TAPS taps. Coefficients read as zero until written.
module fir_lowpass_saturating #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fls_in_if.sink                         in_ch,
  fls_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fls_pkg::APB_AW-1:0]     paddr,
  input  logic [fls_pkg::APB_DW-1:0]     pwdata,
  output logic [fls_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import fls_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [TAPS_BITS-1:0]          taps_r;
  logic [CW-1:0]                 eff_taps;
  logic [CW-1:0]                 fill_r;
  logic [CW-1:0]                 cnt_r;
  logic [AW-1:0]                 wp_r;
  logic [AW-1:0]                 rd_addr_r;
  logic [AW:0]                   base_tmp;
  logic [AW-1:0]                 base;
  logic signed [SAMPLE_BITS-1:0] hold_r;

  logic signed [SAMPLE_BITS-1:0] win_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           coef_vld_r;
  logic signed [SAMPLE_BITS-1:0] rd_s_r;
  logic signed [COEF_BITS-1:0]   rd_c_r;
  logic                          rd_cv_r;
  logic                          d_vld_r;

  logic                          acc_in;
  logic                          acc_smp;
  logic                          acc_coef;
  logic                          full;
  logic                          issue;
  logic                          finish;
  logic                          win_we;
  logic signed [SAMPLE_BITS-1:0] win_wdata;
  logic                          coef_we;
  logic [AW-1:0]                 coef_waddr;

  mac_ctrl_t                     mac_ctrl;
  logic                          mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_filt;
  logic                          mac_sat;

  logic                          out_vld_r;
  logic signed [SAMPLE_BITS-1:0] out_filt_r;
  logic                          out_sat_r;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= TAPS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TAPS_IN_USE)) begin
      taps_r <= pwdata[TAPS_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TAPS_IN_USE) ? APB_DW'(taps_r) : '0;

  always_comb begin
    priority if (taps_r == '0) begin
      eff_taps = CW'(1);
    end else if (32'(taps_r) > MAX_TAPS) begin
      eff_taps = CW'(MAX_TAPS);
    end else begin
      eff_taps = CW'(taps_r);
    end
  end

  // handshake and decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign acc_smp     = acc_in && (in_ch.req_type == REQ_SAMPLE);
  assign acc_coef    = acc_in && (in_ch.req_type == REQ_COEF)
                       && (32'(in_ch.coef_index) < MAX_TAPS);
  assign full        = (fill_r >= eff_taps);
  assign issue       = (state_r == S_RUN);
  assign finish      = (state_r == S_DRAIN) && !d_vld_r && !mac_busy
                       && (!out_vld_r || out_ch.ready);

  // oldest sample of the window sits at wp - taps
  assign base_tmp = {1'b0, wp_r} + (AW+1)'(MAX_TAPS) - (AW+1)'(eff_taps);
  assign base     = (base_tmp >= (AW+1)'(MAX_TAPS)) ? AW'(base_tmp - (AW+1)'(MAX_TAPS))
                                                    : AW'(base_tmp);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_smp && full) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (cnt_r == eff_taps - CW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (finish) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      wp_r    <= '0;
      cnt_r   <= '0;
      d_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      d_vld_r <= issue;
      if (acc_smp) cnt_r <= '0;
      else if (issue) cnt_r <= cnt_r + CW'(1);
      if (win_we) begin
        wp_r <= (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
        if (fill_r < CW'(MAX_TAPS)) fill_r <= fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_smp) begin
      hold_r    <= in_ch.sample_in;
      rd_addr_r <= base;
    end else if (issue) begin
      rd_addr_r <= (rd_addr_r == AW'(MAX_TAPS - 1)) ? '0 : rd_addr_r + AW'(1);
    end
  end

  // sample window, circular
  assign win_we    = (acc_smp && !full) || finish;
  assign win_wdata = finish ? hold_r : in_ch.sample_in;

  always_ff @(posedge clk) begin
    if (win_we) win_mem[wp_r] <= win_wdata;
    if (issue) rd_s_r <= win_mem[rd_addr_r];
  end

  // coefficient store
  assign coef_we    = acc_coef;
  assign coef_waddr = AW'(in_ch.coef_index);

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= in_ch.coef_value;
    if (issue) rd_c_r <= coef_mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      rd_cv_r    <= 1'b0;
    end else begin
      if (coef_we) coef_vld_r[coef_waddr] <= 1'b1;
      if (issue) rd_cv_r <= coef_vld_r[cnt_r[AW-1:0]];
    end
  end

  assign mac_ctrl.clr = acc_smp;
  assign mac_ctrl.vld = d_vld_r;

  fls_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mac_ctrl),
    .smp      (rd_s_r),
    .coef     (rd_cv_r ? rd_c_r : '0),
    .busy     (mac_busy),
    .res_filt (mac_filt),
    .res_sat  (mac_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (finish) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_filt_r <= mac_filt;
      out_sat_r  <= mac_sat;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.filtered  = out_filt_r;
  assign out_ch.saturated = out_sat_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_TAPS))
    else $error("fill count beyond window depth");

  a_full_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    acc_smp && full |=> state_r == S_RUN)
    else $error("sample on full window did not start a run");

  a_beat_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == S_DRAIN)
    else $error("result beat without a finished run");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> cnt_r < eff_taps)
    else $error("tap counter ran past tap count");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the saturating lowpass fir filter
// ----------------------------------------------------------------------------
// A software copy of the filter (sample history, coefficient store, fill
// count and tap register) is updated on every accepted request beat. Each
// sample beat on a full window queues one expected output, and every output
// beat is compared with the oldest queued one. Directed beats cover the field
// extremes, rounding ties, clamping at both ends, an exact +1.0 sum, a window
// that is not yet full, and tap counts of zero, too large and changed
// mid-stream. Random phases follow, each under its own tap count, with a
// bursty sender and a stalling receiver; a long receiver hold-off precedes them.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fls_pkg::*;

  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SETTLE_CYC  = MAX_TAPS + 16;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } fir_result_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  fls_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  fls_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  fir_lowpass_saturating #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // filter copy
  logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  int unsigned                   fill_cnt;
  logic [TAPS_BITS-1:0]          taps_cfg;

  fir_result_t pending_results [$];

  int unsigned err_cnt;
  int unsigned sample_cnt;
  int unsigned coef_cnt;
  int unsigned result_cnt;
  int unsigned sat_cnt;
  int unsigned setting_cnt;
  int unsigned burst_left;
  int unsigned hold_cycles;

  localparam logic [APB_AW-1:0] TAPS_ADDR = APB_AW'(4 * int'(REG_TAPS_IN_USE));

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic fir_result_t filter_sum();
    int unsigned n;
    longint      acc;
    longint      r;
    fir_result_t res;
    n = (taps_cfg == 0) ? 1 : (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
    acc = 0;
    for (int j = 0; j < n; j++) begin
      acc += longint'(hist[n-1-j]) * longint'(coef_mem[j]);
    end
    r = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    res.saturated = 1'b0;
    if (r > 32767) begin
      r = 32767;
      res.saturated = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      res.saturated = 1'b1;
    end
    res.filtered = SAMPLE_BITS'(r);
    return res;
  endfunction

  // request beats update the filter copy
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.req_type == REQ_COEF) begin
        coef_cnt++;
        if (int'(in_ch.coef_index) < MAX_TAPS) coef_mem[in_ch.coef_index] = in_ch.coef_value;
      end else begin
        sample_cnt++;
        if (fill_cnt >= ((taps_cfg == 0) ? 1 :
                         (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg))) begin
          pending_results = {pending_results, filter_sum()};
        end
        for (int j = MAX_TAPS - 1; j > 0; j--) hist[j] = hist[j-1];
        hist[0] = in_ch.sample_in;
        if (fill_cnt < MAX_TAPS) fill_cnt++;
      end
    end
  end

  // result beats against the oldest expectation
  always @(posedge clk) begin
    fir_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: filtered %0d saturated %0b",
               out_ch.filtered, out_ch.saturated);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        result_cnt++;
        if (want.saturated) sat_cnt++;
        if (out_ch.filtered !== want.filtered) begin
          $error("filtered: expected %0d, actual %0d", want.filtered, out_ch.filtered);
          err_cnt++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, out_ch.saturated);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    int unsigned rx_phase;
    rx_mode = 0;
    rx_left = 0;
    rx_phase = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_phase++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_ch.ready <= (rx_phase % 5 == 0);
          end
          default: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  task automatic send_req(input logic req, input logic [IDX_BITS-1:0] idx,
                          input logic signed [COEF_BITS-1:0] cval,
                          input logic signed [SAMPLE_BITS-1:0] samp);
    int unsigned gap;
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= cval;
    in_ch.sample_in  <= samp;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_coef(input int idx, input int val);
    send_req(REQ_COEF, IDX_BITS'(idx), COEF_BITS'(val), '0);
  endtask

  task automatic send_sample(input int val);
    send_req(REQ_SAMPLE, IDX_BITS'($urandom), COEF_BITS'($urandom), SAMPLE_BITS'(val));
  endtask

  // sender waits for every result, then for the tail of any pending work
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == TAPS_ADDR) taps_cfg = data[TAPS_BITS-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("taps_in_use: expected %0d, actual %0d", want, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_taps(input int unsigned taps);
    settle();
    cfg_write(TAPS_ADDR, {APB_DW'($urandom) & ~APB_DW'(6'h3f)} | APB_DW'(taps));
    cfg_read_check(TAPS_ADDR, APB_DW'(taps));
    setting_cnt++;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0:       return 32767;
      1:       return -32768;
      2:       return int'($urandom_range(0, 255)) - 128;
      default: return int'(signed'(16'($urandom)));
    endcase
  endfunction

  function automatic int rand_coef(input bit narrow);
    if (narrow) return int'($urandom_range(0, 4095)) - 2048;
    case ($urandom_range(0, 5))
      0:       return 131071;
      1:       return -131072;
      2:       return 0;
      default: return int'(signed'(18'($urandom)));
    endcase
  endfunction

  task automatic test_register_access();
    cfg_read_check(TAPS_ADDR, APB_DW'(TAPS_RESET));
    cfg_write(TAPS_ADDR, 32'hffff_ffff);
    cfg_read_check(TAPS_ADDR, 32'd63);
    cfg_write(TAPS_ADDR, 32'd0);
    cfg_read_check(TAPS_ADDR, 32'd0);
  endtask

  task automatic test_directed();
    // window filling from reset, clamping at both ends
    set_taps(2);
    send_coef(0, 131071);
    send_coef(1, -131072);
    send_coef(31, -1);
    send_sample(32767);
    send_sample(-32768);
    send_sample(32767);
    send_sample(-32768);
    // longer window while only partly filled
    set_taps(5);
    send_sample(0);
    send_sample(0);
    send_sample(0);
    // exact +1.0, exact -1.0 and rounding ties
    set_taps(1);
    send_coef(0, 65538);
    send_sample(32767);
    send_sample(-32768);
    send_coef(0, 65536);
    send_sample(1);
    send_sample(-1);
    send_coef(0, 32768);
    send_sample(0);
    send_sample(5);
    // zero taps acts as one, oversized acts as the maximum
    set_taps(0);
    send_sample(100);
    send_sample(-200);
    set_taps(63);
    send_sample(7);
    send_sample(-7);
  endtask

  task automatic test_backpressure();
    set_taps(4);
    for (int i = 0; i < 4; i++) send_coef(i, rand_coef(1'b1));
    hold_cycles = 400;
    for (int i = 0; i < 26; i++) send_sample(rand_sample());
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned tap_list [12];
    tap_list = '{3, 32, 1, 17, 0, 63, 8, 2, 33, 31, 12, 6};
    for (int p = 0; p < 12; p++) begin
      set_taps(tap_list[p]);
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_coef($urandom_range(0, MAX_TAPS - 1), rand_coef(p[0]));
        end else begin
          send_sample(rand_sample());
        end
      end
    end
  endtask

  initial begin
    err_cnt     = 0;
    sample_cnt  = 0;
    coef_cnt    = 0;
    result_cnt  = 0;
    sat_cnt     = 0;
    setting_cnt = 0;
    burst_left  = 1;
    hold_cycles = 0;
    fill_cnt    = 0;
    taps_cfg    = TAPS_RESET;
    for (int j = 0; j < MAX_TAPS; j++) begin
      hist[j]     = '0;
      coef_mem[j] = '0;
    end
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_COEF;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.sample_in  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed();
    test_backpressure();
    test_random_phases();
    settle();

    $display("covered %0d sample beats and %0d coefficient beats over %0d tap settings",
             sample_cnt, coef_cnt, setting_cnt);
    $display("checked %0d filtered outputs, %0d of them clamped", result_cnt, sat_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fls_pkg.sv
src/fls_if.sv
src/fls_mac.sv
src/fir_lowpass_saturating.sv
verif/tb_top.sv
